FILE: rtl/core/assert_macros.svh
// concurrent assertion helpers, sampled on clk_i and disabled during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/pip_pkg.sv
package pip_pkg;

  localparam int COORD_BITS   = 16;
  localparam int MAX_VERTICES = 256;
  localparam int IDX_BITS     = $clog2(MAX_VERTICES);
  localparam int CNT_BITS     = IDX_BITS + 1;
  localparam int DIFF_BITS    = COORD_BITS + 1;
  localparam int PROD_BITS    = 2 * DIFF_BITS;
  localparam int MIN_VERTS    = 3;

  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] REG_REF_X = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_REF_Y = 1'b1;

  localparam logic signed [COORD_BITS-1:0] REF_X_RST = COORD_BITS'(1);
  localparam logic signed [COORD_BITS-1:0] REF_Y_RST = COORD_BITS'(0);

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD0,
    ST_LD1,
    ST_SB,
    ST_CHK,
    ST_ECHK,
    ST_SEG_C,
    ST_SEG_D,
    ST_SEG_E,
    ST_W_PEND,
    ST_W_CLOSE,
    ST_FIN
  } state_e;

  // which segment pair the shared segment test is working on
  typedef enum logic [2:0] {
    K_PEND,
    K_EDGE,
    K_WPEND,
    K_CLOSE,
    K_CFIX
  } kind_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } pt_t;

  // orientation sign: neither bit set means collinear
  typedef struct packed {
    logic pos;
    logic neg;
  } sgn_t;

  function automatic logic sgn_is_zero(sgn_t s);
    return !(s.pos | s.neg);
  endfunction

  // product of two signs is not positive
  function automatic logic sgn_prod_le0(sgn_t a, sgn_t b);
    return !((a.pos & b.pos) | (a.neg & b.neg));
  endfunction

endpackage

FILE: rtl/core/pip_ram.sv
module pip_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/pip_orient.sv
module pip_orient import pip_pkg::*; (
  input  logic clk_i,
  input  pt_t  a_i,
  input  pt_t  b_i,
  input  pt_t  c_i,
  output sgn_t sgn_o
);

  // sign of (b - a) x (c - a), products registered, compare after
  logic signed [DIFF_BITS-1:0] dx_ab, dy_ac, dy_ab, dx_ac;
  logic signed [PROD_BITS-1:0] l_d, r_d, l_q, r_q;

  assign dx_ab = $signed({b_i.x[COORD_BITS-1], b_i.x}) - $signed({a_i.x[COORD_BITS-1], a_i.x});
  assign dy_ac = $signed({c_i.y[COORD_BITS-1], c_i.y}) - $signed({a_i.y[COORD_BITS-1], a_i.y});
  assign dy_ab = $signed({b_i.y[COORD_BITS-1], b_i.y}) - $signed({a_i.y[COORD_BITS-1], a_i.y});
  assign dx_ac = $signed({c_i.x[COORD_BITS-1], c_i.x}) - $signed({a_i.x[COORD_BITS-1], a_i.x});

  assign l_d = PROD_BITS'(dx_ab) * PROD_BITS'(dy_ac);
  assign r_d = PROD_BITS'(dy_ab) * PROD_BITS'(dx_ac);

  always_ff @(posedge clk_i) begin
    l_q <= l_d;
    r_q <= r_d;
  end

  assign sgn_o.pos = l_q > r_q;
  assign sgn_o.neg = l_q < r_q;

endmodule

FILE: rtl/core/point_in_polygon_crossing_test_top.sv
// point in polygon test by crossing count over a stored vertex list
//
// input channel (in_valid_i / in_stall_o): one beat is op_i with coord_x_i/coord_y_i.
//   clear and append finish in the cycle the beat is taken and give no result.
//   a query gives exactly one result beat on the output channel.
// output channel (out_valid_o / out_stall_i): one register holds the result;
//   it stays put while out_stall_i is high, and a finished query waits in its
//   last step until that register is free or being taken.
// configuration: cfg_we_i writes ref_x (index 0) or ref_y (index 1).
// walk: a query on fewer than three vertices goes straight to the final step;
//   otherwise every vertex is read and its sign against the query line taken,
//   and each segment pair that passes the sign screen gets the full test, also
//   the pairs that settle a vertex that sits on the query line.
// queries: in_stall_o is high for the whole query, so queries run one at a
//   time; the shared orientation unit and the single vertex ram read port pace
//   the walk over the vertices. clear and append never raise in_stall_o.
// reset: rst_ni low clears the vertex count, the drop flag and the output valid,
//   and sets the reference point to (1, 0). ram contents are left as they are;
//   only entries below the count are ever read.
`include "assert_macros.svh"

module point_in_polygon_crossing_test_top import pip_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input beats
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    op_i,
  input  logic signed [COORD_BITS-1:0]  coord_x_i,
  input  logic signed [COORD_BITS-1:0]  coord_y_i,
  // result beats
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          inside_res_o,
  output logic [CNT_BITS-1:0]           crossings_o,
  output logic [CNT_BITS-1:0]           vertex_corrections_o,
  output logic                          degenerate_o,
  output logic                          append_dropped_o,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]       cfg_idx_i,
  input  logic [COORD_BITS-1:0]         cfg_wdata_i
);

  // control state
  state_e              state_q, state_d;
  kind_e               kind_q, kind_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic                ovf_q, ovf_d;
  logic [CNT_BITS-1:0] hits_q, hits_d;
  logic [CNT_BITS-1:0] fixes_q, fixes_d;
  logic                pend_q, pend_d;
  logic                out_valid_q, out_valid_d;
  logic signed [COORD_BITS-1:0] ref_x_q, ref_y_q;

  // walk payload
  logic [IDX_BITS-1:0] idx_q, idx_d;
  logic [CNT_BITS-1:0] n_q, n_d;
  pt_t                 p_q, p_d;
  pt_t                 a_q, a_d;     // previous vertex
  pt_t                 b_q, b_d;     // current vertex
  pt_t                 v0_q, v0_d;
  pt_t                 v1_q, v1_d;
  pt_t                 pv_q, pv_d;   // start of an edge whose far vertex sits on the line
  sgn_t                sa_q, sa_d, sb_q, sb_d, s0_q, s0_d, s1_q, s1_d;
  sgn_t                spv_q, spv_d, c_q, c_d;

  // result register
  logic                res_inside_q, res_inside_d;
  logic [CNT_BITS-1:0] res_cross_q, res_cross_d;
  logic [CNT_BITS-1:0] res_fix_q, res_fix_d;
  logic                res_degen_q, res_degen_d;
  logic                res_drop_q, res_drop_d;

  // ram and orientation unit hookup
  logic                ram_we, ram_re;
  logic [IDX_BITS-1:0] ram_waddr, ram_raddr;
  pt_t                 ram_wdata, ram_rdata;
  pt_t                 ref_pt, e1, e2;
  pt_t                 op_a, op_b, op_c;
  sgn_t                unit_sgn;

  logic                in_accept;
  logic [CNT_BITS-1:0] idx_ext, nxt_idx;
  logic                more;
  sgn_t                sb_cur;
  logic                seg_hit;
  logic                pend_pre, edge_pre;

  assign ref_pt    = '{x: ref_x_q, y: ref_y_q};
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign ram_wdata  = '{x: coord_x_i, y: coord_y_i};

  assign idx_ext = {1'b0, idx_q};
  assign nxt_idx = idx_ext + CNT_BITS'(1);
  assign more    = nxt_idx < n_q;

  pip_ram #(
    .WIDTH($bits(pt_t)),
    .DEPTH(MAX_VERTICES)
  ) u_vram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  pip_orient u_orient (
    .clk_i(clk_i),
    .a_i  (op_a),
    .b_i  (op_b),
    .c_i  (op_c),
    .sgn_o(unit_sgn)
  );

  // segment pair under test
  always_comb begin
    unique case (kind_q)
      K_PEND:  begin e1 = pv_q; e2 = b_q;  end
      K_EDGE:  begin e1 = a_q;  e2 = b_q;  end
      K_WPEND: begin e1 = pv_q; e2 = v0_q; end
      K_CLOSE: begin e1 = v0_q; e2 = a_q;  end
      K_CFIX:  begin e1 = a_q;  e2 = v1_q; end
      default: begin e1 = a_q;  e2 = b_q;  end
    endcase
  end

  // orientation unit operands: vertex against the query line, or the
  // reference / query point against the pair under test
  always_comb begin
    unique case (state_q)
      ST_SEG_C: begin op_a = e1; op_b = e2; op_c = ref_pt; end
      ST_SEG_D: begin op_a = e1; op_b = e2; op_c = p_q;    end
      default:  begin op_a = ref_pt; op_b = p_q; op_c = ram_rdata; end
    endcase
  end

  // sign of the current vertex is straight off the unit in the check step
  assign sb_cur   = (state_q == ST_CHK) ? unit_sgn : sb_q;
  assign seg_hit  = sgn_prod_le0(c_q, unit_sgn);
  assign pend_pre = pend_q && (pv_q != b_q) && sgn_prod_le0(spv_q, sb_cur);
  assign edge_pre = (a_q != b_q) && sgn_prod_le0(sa_q, sb_cur);

  always_comb begin
    state_d      = state_q;
    kind_d       = kind_q;
    cnt_d        = cnt_q;
    ovf_d        = ovf_q;
    hits_d       = hits_q;
    fixes_d      = fixes_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q;
    idx_d        = idx_q;
    n_d          = n_q;
    p_d          = p_q;
    a_d          = a_q;
    b_d          = b_q;
    v0_d         = v0_q;
    v1_d         = v1_q;
    pv_d         = pv_q;
    sa_d         = sa_q;
    sb_d         = sb_q;
    s0_d         = s0_q;
    s1_d         = s1_q;
    spv_d        = spv_q;
    c_d          = c_q;
    res_inside_d = res_inside_q;
    res_cross_d  = res_cross_q;
    res_fix_d    = res_fix_q;
    res_degen_d  = res_degen_q;
    res_drop_d   = res_drop_q;
    ram_we       = 1'b0;
    ram_waddr    = cnt_q[IDX_BITS-1:0];
    ram_re       = 1'b0;
    ram_raddr    = nxt_idx[IDX_BITS-1:0];

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          unique case (op_i)
            OP_CLEAR: begin
              cnt_d = '0;
              ovf_d = 1'b0;
            end
            OP_APPEND: begin
              if (cnt_q == CNT_BITS'(MAX_VERTICES)) begin
                ovf_d = 1'b1;
              end else begin
                ram_we = 1'b1;
                cnt_d  = cnt_q + CNT_BITS'(1);
              end
            end
            OP_QUERY: begin
              p_d     = '{x: coord_x_i, y: coord_y_i};
              n_d     = cnt_q;
              hits_d  = '0;
              fixes_d = '0;
              pend_d  = 1'b0;
              if (cnt_q < CNT_BITS'(MIN_VERTS)) begin
                state_d = ST_FIN;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                state_d   = ST_LD0;
              end
            end
            default: ;  // unused op code: nothing happens
          endcase
        end
      end

      ST_LD0: begin
        // v0 on the read port, its sign issued
        v0_d      = ram_rdata;
        a_d       = ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = IDX_BITS'(1);
        state_d   = ST_LD1;
      end

      ST_LD1: begin
        s0_d    = unit_sgn;
        sa_d    = unit_sgn;
        idx_d   = IDX_BITS'(1);
        state_d = ST_SB;
      end

      ST_SB: begin
        b_d = ram_rdata;
        if (idx_q == IDX_BITS'(1)) begin
          v1_d = ram_rdata;
        end
        state_d = ST_CHK;
      end

      ST_CHK: begin
        sb_d = unit_sgn;
        if (idx_q == IDX_BITS'(1)) begin
          s1_d = unit_sgn;
        end
        // prefetch next vertex; read data holds until the next SB
        ram_re = more;
        if (pend_pre) begin
          kind_d  = K_PEND;
          state_d = ST_SEG_C;
        end else begin
          pend_d = 1'b0;
          if (edge_pre) begin
            kind_d  = K_EDGE;
            state_d = ST_SEG_C;
          end else begin
            a_d  = b_q;
            sa_d = sb_cur;
            if (more) begin
              idx_d   = nxt_idx[IDX_BITS-1:0];
              state_d = ST_SB;
            end else begin
              state_d = ST_W_PEND;
            end
          end
        end
      end

      ST_ECHK: begin
        if (edge_pre) begin
          kind_d  = K_EDGE;
          state_d = ST_SEG_C;
        end else begin
          a_d  = b_q;
          sa_d = sb_cur;
          if (more) begin
            idx_d   = nxt_idx[IDX_BITS-1:0];
            state_d = ST_SB;
          end else begin
            state_d = ST_W_PEND;
          end
        end
      end

      ST_SEG_C: state_d = ST_SEG_D;

      ST_SEG_D: begin
        c_d     = unit_sgn;
        state_d = ST_SEG_E;
      end

      ST_SEG_E: begin
        unique case (kind_q)
          K_PEND: begin
            if (seg_hit) fixes_d = fixes_q + CNT_BITS'(1);
            pend_d  = 1'b0;
            state_d = ST_ECHK;
          end
          K_EDGE: begin
            if (seg_hit) begin
              hits_d = hits_q + CNT_BITS'(1);
              // far vertex on the line: check its neighbours once the next one is in
              if (sgn_is_zero(sb_q)) begin
                pend_d = 1'b1;
                pv_d   = a_q;
                spv_d  = sa_q;
              end
            end
            a_d  = b_q;
            sa_d = sb_q;
            if (more) begin
              idx_d   = nxt_idx[IDX_BITS-1:0];
              state_d = ST_SB;
            end else begin
              state_d = ST_W_PEND;
            end
          end
          K_WPEND: begin
            if (seg_hit) fixes_d = fixes_q + CNT_BITS'(1);
            pend_d  = 1'b0;
            state_d = ST_W_CLOSE;
          end
          K_CLOSE: begin
            if (seg_hit) hits_d = hits_q + CNT_BITS'(1);
            // closing edge through v0: test v[n-1] against v1
            if (seg_hit && sgn_is_zero(s0_q) && (a_q != v1_q) &&
                sgn_prod_le0(sa_q, s1_q)) begin
              kind_d  = K_CFIX;
              state_d = ST_SEG_C;
            end else begin
              state_d = ST_FIN;
            end
          end
          K_CFIX: begin
            if (seg_hit) fixes_d = fixes_q + CNT_BITS'(1);
            state_d = ST_FIN;
          end
          default: state_d = ST_FIN;
        endcase
      end

      ST_W_PEND: begin
        // last edge's pending check wraps to v0
        if (pend_q && (pv_q != v0_q) && sgn_prod_le0(spv_q, s0_q)) begin
          kind_d  = K_WPEND;
          state_d = ST_SEG_C;
        end else begin
          pend_d  = 1'b0;
          state_d = ST_W_CLOSE;
        end
      end

      ST_W_CLOSE: begin
        // a_q now holds v[n-1]
        if ((v0_q != a_q) && sgn_prod_le0(s0_q, sa_q)) begin
          kind_d  = K_CLOSE;
          state_d = ST_SEG_C;
        end else begin
          state_d = ST_FIN;
        end
      end

      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          res_inside_d = hits_q[0] ^ fixes_q[0];
          res_cross_d  = hits_q;
          res_fix_d    = fixes_q;
          res_degen_d  = n_q < CNT_BITS'(MIN_VERTS);
          res_drop_d   = ovf_q;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kind_q      <= K_EDGE;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      hits_q      <= '0;
      fixes_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      ref_x_q     <= REF_X_RST;
      ref_y_q     <= REF_Y_RST;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      hits_q      <= hits_d;
      fixes_q     <= fixes_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_REF_X: ref_x_q <= $signed(cfg_wdata_i);
          REG_REF_Y: ref_y_q <= $signed(cfg_wdata_i);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    n_q          <= n_d;
    p_q          <= p_d;
    a_q          <= a_d;
    b_q          <= b_d;
    v0_q         <= v0_d;
    v1_q         <= v1_d;
    pv_q         <= pv_d;
    sa_q         <= sa_d;
    sb_q         <= sb_d;
    s0_q         <= s0_d;
    s1_q         <= s1_d;
    spv_q        <= spv_d;
    c_q          <= c_d;
    res_inside_q <= res_inside_d;
    res_cross_q  <= res_cross_d;
    res_fix_q    <= res_fix_d;
    res_degen_q  <= res_degen_d;
    res_drop_q   <= res_drop_d;
  end

  assign out_valid_o          = out_valid_q;
  assign inside_res_o         = res_inside_q;
  assign crossings_o          = res_cross_q;
  assign vertex_corrections_o = res_fix_q;
  assign degenerate_o         = res_degen_q;
  assign append_dropped_o     = res_drop_q;

  // corrections are only counted on edges that already crossed
  `ASSERT_IMPLIES(a_fix_le_hit, state_q != ST_IDLE, fixes_q <= hits_q,
                  "vertex corrections exceed crossings")
  // the walk never addresses past the stored vertices
  `ASSERT_IMPLIES(a_idx_in_range, state_q == ST_SB, idx_ext < n_q,
                  "vertex index beyond count")
  // a query on a real polygon starts the walk at v0
  `ASSERT_NEXT(a_query_walk, in_accept && (op_i == OP_QUERY) &&
               (cnt_q >= CNT_BITS'(MIN_VERTS)), state_q == ST_LD0,
               "query did not start the vertex walk")
  // only the final step loads the result register
  `ASSERT_NEXT(a_out_from_fin, !out_valid_q && (state_q != ST_FIN), !out_valid_q,
               "result shown without a finished query")

endmodule
